// ===== hdl/mivm_pkg.sv =====
`default_nettype none

package mivm_pkg;

	// command codes
	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_STEP  = 2'd2;

	// status codes
	localparam logic [2:0] ST_RUN    = 3'd0;
	localparam logic [2:0] ST_HALT   = 3'd1;
	localparam logic [2:0] ST_OVF    = 3'd2;
	localparam logic [2:0] ST_BADCHR = 3'd3;
	localparam logic [2:0] ST_BADOP  = 3'd4;

	// output kinds
	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_INT  = 2'd1;
	localparam logic [1:0] KIND_CHR  = 2'd2;

	// opcodes
	localparam logic [3:0] OP_HALT      = 4'd0;
	localparam logic [3:0] OP_ADD       = 4'd1;
	localparam logic [3:0] OP_MUL       = 4'd2;
	localparam logic [3:0] OP_SUB       = 4'd3;
	localparam logic [3:0] OP_COPY      = 4'd4;
	localparam logic [3:0] OP_JUMP      = 4'd5;
	localparam logic [3:0] OP_READ      = 4'd6;
	localparam logic [3:0] OP_PRINT_INT = 4'd7;
	localparam logic [3:0] OP_PRINT_CHR = 4'd8;

	localparam logic [31:0] CHAR_MAX = 32'd127;

	typedef struct packed {
		logic [31:0] pc;
		logic [31:0] value;
		logic [1:0]  kind;
		logic [2:0]  status;
	} res_t;

	function automatic res_t mk_res(input logic [2:0] st, input logic [1:0] kd,
			input logic [31:0] v, input logic [31:0] p);
		res_t r;
		r.status = st;
		r.kind   = kd;
		r.value  = v;
		r.pc     = p;
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/mivm_ram.sv =====
`default_nettype none

module mivm_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [31:0]   wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [31:0]   rdata
);

	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/mivm_seq.sv =====
`default_nettype none

module mivm_seq
	import mivm_pkg::*;
#(
	parameter int MEM_WORDS = 1024,
	parameter int AW        = 10
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [1:0]    cmd,
	input  wire logic [9:0]    waddr,
	input  wire logic [31:0]   wval,
	input  wire logic [10:0]   words_in_use,
	input  wire logic          out_free,
	output logic               done_valid,
	output res_t               res,
	output logic               ram_we,
	output logic [AW-1:0]      ram_waddr,
	output logic [31:0]        ram_wdata,
	output logic               ram_re,
	output logic [AW-1:0]      ram_raddr,
	input  wire logic [31:0]   ram_rdata
);

	localparam logic [31:0] MemWords = 32'(MEM_WORDS);

	typedef enum logic [2:0] {
		S_IDLE, S_OPC, S_OP1, S_VAL1, S_OP2, S_VAL2, S_OP3, S_DONE
	} state_t;

	state_t      state_q;
	logic [31:0] pc_q;
	logic        run_q;
	logic [3:0]  code_q;
	logic [31:0] a_q;
	logic [31:0] alu_q;
	logic [31:0] wval_q;
	res_t        res_q;

	logic [31:0] limit;
	logic [31:0] pc_inc;
	logic [31:0] pc_inc2;
	logic [31:0] waddr32;
	logic        pc_ok;
	logic        fetch_ok;
	logic        rdata_ok;
	logic        load_ok;
	logic        arith;
	logic [31:0] rd_addr;
	logic [31:0] wr_addr;
	logic [31:0] alu_d;

	assign limit    = (32'(words_in_use) < MemWords) ? 32'(words_in_use) : MemWords;
	assign pc_inc   = pc_q + 32'd1;
	assign pc_inc2  = pc_q + 32'd2;
	assign waddr32  = 32'(waddr);
	assign pc_ok    = pc_q < limit;
	assign fetch_ok = pc_inc < limit;
	assign rdata_ok = ram_rdata < limit;
	assign load_ok  = waddr32 < MemWords;
	assign arith    = (code_q == OP_ADD) || (code_q == OP_MUL) || (code_q == OP_SUB);

	always_comb begin
		case (code_q)
			OP_ADD:  alu_d = a_q + ram_rdata;
			OP_MUL:  alu_d = a_q * ram_rdata;
			OP_SUB:  alu_d = a_q - ram_rdata;
			default: alu_d = '0;
		endcase
	end

	// memory port control
	always_comb begin
		ram_re    = 1'b0;
		rd_addr   = pc_q;
		ram_we    = 1'b0;
		wr_addr   = ram_rdata;
		ram_wdata = wval_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid && cmd == CMD_STEP && run_q && pc_ok) begin
					ram_re = 1'b1;
				end
				if (in_valid && cmd == CMD_LOAD && load_ok) begin
					ram_we    = 1'b1;
					wr_addr   = waddr32;
					ram_wdata = wval;
				end
			end
			S_OPC: begin
				if (ram_rdata != 32'd0 && ram_rdata <= 32'(OP_PRINT_CHR) && fetch_ok) begin
					ram_re  = 1'b1;
					rd_addr = pc_inc;
				end
			end
			S_OP1: begin
				if (code_q == OP_READ) begin
					ram_we = rdata_ok;
				end else begin
					ram_re  = rdata_ok;
					rd_addr = ram_rdata;
				end
			end
			S_VAL1: begin
				if (code_q != OP_PRINT_INT && code_q != OP_PRINT_CHR && fetch_ok) begin
					ram_re  = 1'b1;
					rd_addr = pc_inc;
				end
			end
			S_OP2: begin
				ram_re  = rdata_ok;
				rd_addr = ram_rdata;
			end
			S_VAL2: begin
				ram_re  = fetch_ok;
				rd_addr = pc_inc;
			end
			S_OP3: begin
				if ((arith || code_q == OP_COPY) && rdata_ok) begin
					ram_we    = 1'b1;
					ram_wdata = (code_q == OP_COPY) ? a_q : alu_q;
				end
			end
			default: ;
		endcase
	end

	assign ram_raddr  = rd_addr[AW-1:0];
	assign ram_waddr  = wr_addr[AW-1:0];
	assign in_ready   = state_q == S_IDLE;
	assign done_valid = (state_q == S_DONE) && out_free;
	assign res        = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q    <= '0;
			run_q   <= 1'b0;
			code_q  <= OP_HALT;
			a_q     <= '0;
			alu_q   <= '0;
			wval_q  <= '0;
			res_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						wval_q <= wval;
						case (cmd)
							CMD_START: begin
								pc_q    <= '0;
								run_q   <= 1'b1;
								res_q   <= mk_res(ST_RUN, KIND_NONE, '0, '0);
								state_q <= S_DONE;
							end
							CMD_STEP: begin
								if (run_q && pc_ok) begin
									state_q <= S_OPC;
								end else if (run_q) begin
									run_q   <= 1'b0;
									res_q   <= mk_res(ST_OVF, KIND_NONE, '0, pc_q);
									state_q <= S_DONE;
								end else begin
									res_q   <= mk_res(ST_HALT, KIND_NONE, '0, pc_q);
									state_q <= S_DONE;
								end
							end
							default: begin
								res_q   <= mk_res(run_q ? ST_RUN : ST_HALT, KIND_NONE, '0, pc_q);
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_OPC: begin
					if (ram_rdata == 32'd0) begin
						pc_q    <= pc_inc;
						run_q   <= 1'b0;
						res_q   <= mk_res(ST_HALT, KIND_NONE, '0, pc_inc);
						state_q <= S_DONE;
					end else if (ram_rdata <= 32'(OP_PRINT_CHR)) begin
						code_q <= ram_rdata[3:0];
						if (fetch_ok) begin
							pc_q    <= pc_inc;
							state_q <= S_OP1;
						end else begin
							pc_q    <= pc_inc2;
							run_q   <= 1'b0;
							res_q   <= mk_res(ST_OVF, KIND_NONE, '0, pc_inc2);
							state_q <= S_DONE;
						end
					end else begin
						pc_q    <= pc_inc;
						run_q   <= 1'b0;
						res_q   <= mk_res(ST_BADOP, KIND_NONE, '0, pc_inc);
						state_q <= S_DONE;
					end
				end
				S_OP1: begin
					if (code_q == OP_READ) begin
						pc_q    <= pc_inc;
						res_q   <= mk_res(ST_RUN, KIND_NONE, '0, pc_inc);
						state_q <= S_DONE;
					end else if (rdata_ok) begin
						state_q <= S_VAL1;
					end else begin
						pc_q    <= pc_inc;
						run_q   <= 1'b0;
						res_q   <= mk_res(ST_OVF, KIND_NONE, '0, pc_inc);
						state_q <= S_DONE;
					end
				end
				S_VAL1: begin
					a_q <= ram_rdata;
					if (code_q == OP_PRINT_INT) begin
						pc_q    <= pc_inc;
						res_q   <= mk_res(ST_RUN, KIND_INT, ram_rdata, pc_inc);
						state_q <= S_DONE;
					end else if (code_q == OP_PRINT_CHR) begin
						pc_q <= pc_inc;
						if (ram_rdata <= CHAR_MAX) begin
							res_q <= mk_res(ST_RUN, KIND_CHR, ram_rdata, pc_inc);
						end else begin
							run_q <= 1'b0;
							res_q <= mk_res(ST_BADCHR, KIND_NONE, '0, pc_inc);
						end
						state_q <= S_DONE;
					end else if (fetch_ok) begin
						pc_q    <= pc_inc;
						state_q <= arith ? S_OP2 : S_OP3;
					end else begin
						pc_q    <= pc_inc2;
						run_q   <= 1'b0;
						res_q   <= mk_res(ST_OVF, KIND_NONE, '0, pc_inc2);
						state_q <= S_DONE;
					end
				end
				S_OP2: begin
					if (rdata_ok) begin
						state_q <= S_VAL2;
					end else begin
						pc_q    <= pc_inc;
						run_q   <= 1'b0;
						res_q   <= mk_res(ST_OVF, KIND_NONE, '0, pc_inc);
						state_q <= S_DONE;
					end
				end
				S_VAL2: begin
					alu_q <= alu_d;
					if (fetch_ok) begin
						pc_q    <= pc_inc;
						state_q <= S_OP3;
					end else begin
						pc_q    <= pc_inc2;
						run_q   <= 1'b0;
						res_q   <= mk_res(ST_OVF, KIND_NONE, '0, pc_inc2);
						state_q <= S_DONE;
					end
				end
				S_OP3: begin
					// jump taken lands one past the target
					if (code_q == OP_JUMP && !a_q[31]) begin
						pc_q  <= ram_rdata + 32'd1;
						res_q <= mk_res(ST_RUN, KIND_NONE, '0, ram_rdata + 32'd1);
					end else begin
						pc_q  <= pc_inc;
						res_q <= mk_res(ST_RUN, KIND_NONE, '0, pc_inc);
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !ram_re)
		else $error("memory read and write issued together");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |-> (rd_addr < limit))
		else $error("memory read beyond words in use");

	a_stop_reported: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(run_q) |-> (res_q.status != ST_RUN))
		else $error("machine stopped with running status");

	a_accept_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q != S_IDLE))
		else $error("accepted transaction left no result pending");

endmodule

`default_nettype wire

// ===== hdl/memory_indirect_vm_step_core.sv =====
`default_nettype none

// Memory-indirect virtual machine, one command per input transaction.
// Slave stream s_*: command, word address and word value; every accepted
// transaction yields exactly one result transaction on master stream m_*
// (status, output kind, output value, program counter afterwards).
// cfg_we/cfg_wdata write words_in_use; write it only while the core is idle.
// Program and data share one single-port-read RAM of MEM_WORDS words with
// a registered read, so an instruction walks its operand chain one read
// per cycle: opcode, operand address, operand value, and so on.
// For load, start, command 3 and a step that runs no instruction the
// sequencer goes straight to its done state; an executed step first walks
// its operand reads (arithmetic takes the full chain of six dependent reads
// plus the write-back). s_tready rises on the edge that hands the result
// to the output register, so a new transaction is taken only after the
// previous result has been handed over.
// A finished result sits in the output register while the next command is
// already taken; if m_tready stays low the sequencer holds its next result
// and s_tready stays low until the register drains.
// Reset clears the program counter, the run flag and words_in_use; the
// memory contents are not cleared and must be loaded before use.
module memory_indirect_vm_step_core
	import mivm_pkg::*;
#(
	parameter int MEM_WORDS = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,   // command[1:0], word_addr[11:2], word_value[43:12]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [71:0] m_tdata,   // status[2:0], out_kind[4:3], out_value[36:5],
	                                    // next_pc[68:37]
	input  wire logic        cfg_we,
	input  wire logic [10:0] cfg_wdata
);

	localparam int AW = $clog2(MEM_WORDS);

	logic [10:0]   words_in_use_q;
	logic          out_free;
	logic          done_valid;
	res_t          res;
	logic          m_tvalid_q;
	res_t          m_res_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [31:0]   ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [31:0]   ram_rdata;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_in_use_q <= '0;
		end else if (cfg_we) begin
			words_in_use_q <= cfg_wdata;
		end
	end

	mivm_ram #(
		.DEPTH (MEM_WORDS),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	mivm_seq #(
		.MEM_WORDS (MEM_WORDS),
		.AW        (AW)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.cmd          (s_tdata[1:0]),
		.waddr        (s_tdata[11:2]),
		.wval         (s_tdata[43:12]),
		.words_in_use (words_in_use_q),
		.out_free     (out_free),
		.done_valid   (done_valid),
		.res          (res),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.ram_re       (ram_re),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata)
	);

	// output register: takes a new result when empty or draining this cycle
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			m_res_q    <= '0;
		end else if (out_free) begin
			m_tvalid_q <= done_valid;
			if (done_valid) begin
				m_res_q <= res;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, m_res_q.pc, m_res_q.value, m_res_q.kind, m_res_q.status};

endmodule

`default_nettype wire
